FILE: src/hcle_pkg.sv
package hcle_pkg;

  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned LABEL_LEN     = 16;
  localparam int unsigned LABEL_PROG_W  = 5;
  localparam int unsigned TERM_W        = 3;
  localparam int unsigned VALUE_W       = 31;
  localparam int unsigned DIGIT_W       = 4;
  localparam int unsigned MAX_DIGITS_DEF = 63;
  localparam int unsigned QUEUE_DEPTH   = 2;

  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

  localparam logic [TERM_W-1:0] TERM_NONE  = 3'd0;
  localparam logic [TERM_W-1:0] TERM_CR    = 3'd1;
  localparam logic [TERM_W-1:0] TERM_CRLF  = 3'd2;
  localparam logic [TERM_W-1:0] TERM_CRLFCR = 3'd3;
  localparam logic [TERM_W-1:0] TERM_DONE  = 3'd4;

  localparam logic [LABEL_PROG_W-1:0] LABEL_DONE = 5'd16;

  localparam logic [VALUE_W-1:0] VALUE_MAX = 31'h7FFF_FFFF;

  // "Content-Length: "
  localparam logic [BYTE_W-1:0] LABEL_TEXT [LABEL_LEN] = '{
    8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h2D,
    8'h4C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68, 8'h3A, 8'h20
  };

  typedef struct packed {
    logic                 closed;
    logic                 is_digit;
    logic [DIGIT_W-1:0]   digit;
    logic                 is_cr;
    logic                 is_lf;
    logic [LABEL_LEN-1:0] label_hit;
  } item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] content_length;
    logic               label_found;
    logic               header_complete;
  } result_t;

endpackage

FILE: src/hcle_front.sv
module hcle_front (
  input  logic [hcle_pkg::BYTE_W-1:0] data_byte,
  input  logic                        stream_closed,
  output hcle_pkg::item_t             item
);

  always_comb begin
    item.closed   = stream_closed;
    item.is_digit = (data_byte >= hcle_pkg::CHAR_ZERO) && (data_byte <= hcle_pkg::CHAR_NINE);
    item.digit    = data_byte[hcle_pkg::DIGIT_W-1:0];
    item.is_cr    = (data_byte == hcle_pkg::CHAR_CR);
    item.is_lf    = (data_byte == hcle_pkg::CHAR_LF);
    for (int i = 0; i < hcle_pkg::LABEL_LEN; i++) begin
      item.label_hit[i] = (data_byte == hcle_pkg::LABEL_TEXT[i]);
    end
  end

endmodule

FILE: src/hcle_queue.sv
module hcle_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  hcle_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output hcle_pkg::item_t pop_item
);

  localparam int unsigned PTR_W = (hcle_pkg::QUEUE_DEPTH > 1) ?
                                  $clog2(hcle_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(hcle_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(hcle_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(hcle_pkg::QUEUE_DEPTH);

  hcle_pkg::item_t  mem [hcle_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_FULL);
  assign valid    = (count != '0);
  assign pop_item = mem[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: src/hcle_back.sv
module hcle_back #(
  parameter int unsigned MAX_DIGITS = hcle_pkg::MAX_DIGITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  hcle_pkg::item_t   item,
  output logic              item_pop,
  output logic              result_valid,
  input  logic              result_ready,
  output hcle_pkg::result_t result
);

  localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DIGITS);
  localparam int unsigned PROD_W = hcle_pkg::VALUE_W + 4;

  logic [hcle_pkg::TERM_W-1:0]       term;
  logic [hcle_pkg::TERM_W-1:0]       term_next;
  logic [hcle_pkg::LABEL_PROG_W-1:0] label_prog;
  logic [hcle_pkg::LABEL_PROG_W-1:0] label_prog_next;
  logic                              label_seen;
  logic                              label_seen_next;
  logic                              digits_closed;
  logic                              digits_closed_next;
  logic [CNT_W-1:0]                  digit_count;
  logic [CNT_W-1:0]                  digit_count_next;
  logic [hcle_pkg::VALUE_W-1:0]      length_value;
  logic [hcle_pkg::VALUE_W-1:0]      length_value_next;
  logic [PROD_W-1:0]                 product;
  logic                              label_hit;
  logic                              emit;
  hcle_pkg::result_t                 result_next;

  assign item_pop = item_valid && (!result_valid || result_ready);

  assign product = {4'b0, length_value} * PROD_W'(10) + PROD_W'(item.digit);
  assign label_hit = !label_prog[hcle_pkg::LABEL_PROG_W-1] &&
                     item.label_hit[label_prog[hcle_pkg::LABEL_PROG_W-2:0]];

  always_comb begin
    label_prog_next    = label_prog;
    label_seen_next    = label_seen;
    digits_closed_next = digits_closed;
    digit_count_next   = digit_count;
    length_value_next  = length_value;
    term_next          = hcle_pkg::TERM_NONE;

    if (label_seen) begin
      if (!digits_closed) begin
        if (item.is_digit && (digit_count < CNT_MAX)) begin
          length_value_next = (product > PROD_W'(hcle_pkg::VALUE_MAX)) ?
                              hcle_pkg::VALUE_MAX : product[hcle_pkg::VALUE_W-1:0];
          digit_count_next  = digit_count + 1'b1;
          if (digit_count_next >= CNT_MAX) begin
            digits_closed_next = 1'b1;
          end
        end else begin
          digits_closed_next = 1'b1;
        end
      end
    end else begin
      if (label_hit) begin
        label_prog_next = label_prog + 1'b1;
      end else begin
        label_prog_next = item.label_hit[0] ? 5'd1 : 5'd0;
      end
      label_seen_next = (label_prog_next == hcle_pkg::LABEL_DONE);
    end

    if (item.is_cr) begin
      term_next = (term == hcle_pkg::TERM_CRLF) ? hcle_pkg::TERM_CRLFCR : hcle_pkg::TERM_CR;
    end else if (item.is_lf && ((term == hcle_pkg::TERM_CR) ||
                                (term == hcle_pkg::TERM_CRLFCR))) begin
      term_next = term + 1'b1;
    end

    if (item.closed) begin
      emit = 1'b1;
      result_next.content_length  = '0;
      result_next.label_found     = label_seen;
      result_next.header_complete = 1'b0;
    end else begin
      emit = (term_next == hcle_pkg::TERM_DONE);
      result_next.content_length  = (label_seen_next && (digit_count_next != '0)) ?
                                    length_value_next : '0;
      result_next.label_found     = label_seen_next;
      result_next.header_complete = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop && emit) begin
      result <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      term          <= hcle_pkg::TERM_NONE;
      label_prog    <= '0;
      label_seen    <= 1'b0;
      digits_closed <= 1'b0;
      digit_count   <= '0;
      length_value  <= '0;
      result_valid  <= 1'b0;
    end else begin
      if (item_pop && emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (item_pop) begin
        if (emit) begin
          term          <= hcle_pkg::TERM_NONE;
          label_prog    <= '0;
          label_seen    <= 1'b0;
          digits_closed <= 1'b0;
          digit_count   <= '0;
          length_value  <= '0;
        end else begin
          term          <= term_next;
          label_prog    <= label_prog_next;
          label_seen    <= label_seen_next;
          digits_closed <= digits_closed_next;
          digit_count   <= digit_count_next;
          length_value  <= length_value_next;
        end
      end
    end
  end

endmodule

FILE: src/http_content_length_extractor.sv
// HTTP Content-Length extractor.
// Slave stream s_axis takes one header byte per transaction: tdata is the
// byte, tuser marks a closed connection (the byte is then ignored). Master
// stream m_axis gives one transaction per header: tdata holds the parsed
// length and whether the "Content-Length: " label was seen, tuser is set
// when the CR LF CR LF terminator closed the header and clear when the
// connection closed first.
// An accepted byte is written into a two-entry queue; the parser pops it
// from the queue and registers the result, so a byte passes the queue
// entry and then the result register before its result is on m_axis.
// One byte per cycle is sustained unless m_axis stalls; the parser state update
// (label match, one multiply-by-ten and saturating add) is the only step.
// Synchronous active-high rst empties the queue, drops any pending result
// and clears all parser state. While m_axis is stalled with a result held,
// the parser stops and the queue fills; s_axis_tready falls once it is
// full and rises again as soon as the result is taken.
module http_content_length_extractor #(
  parameter int unsigned MAX_DIGITS = hcle_pkg::MAX_DIGITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] stream_closed
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [30:0] content_length, [31] label_found
  output logic        m_axis_tuser    // [0] header_complete
);

  hcle_pkg::item_t   in_item;
  hcle_pkg::item_t   q_item;
  hcle_pkg::result_t result;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;

  assign s_axis_tready = !q_full;

  hcle_front u_front (
    .data_byte     (s_axis_tdata),
    .stream_closed (s_axis_tuser),
    .item          (in_item)
  );

  hcle_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_axis_tvalid),
    .push_item (in_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_item  (q_item)
  );

  hcle_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (q_valid),
    .item         (q_item),
    .item_pop     (q_pop),
    .result_valid (m_axis_tvalid),
    .result_ready (m_axis_tready),
    .result       (result)
  );

  assign m_axis_tdata = {result.label_found, result.content_length};
  assign m_axis_tuser = result.header_complete;

  a_new_result_from_pop: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !($past(m_axis_tvalid) && !$past(m_axis_tready))) |-> $past(q_pop))
    else $error("result appeared without a parsed byte");

  a_stall_holds_parser: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !q_pop)
    else $error("parser advanced while result stalled");

  a_incomplete_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[30:0] == 31'd0))
    else $error("incomplete header carries a length");

  a_backpressure_only_when_busy: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> q_valid)
    else $error("input stalled with empty queue");

endmodule

FILE: bench/tb_http_content_length_extractor.sv
module tb_http_content_length_extractor;

  localparam int unsigned STALL_LIMIT   = 5000;
  localparam int unsigned HOLD_CYCLES   = 120;
  localparam int unsigned DRAIN_CYCLES  = 16;
  localparam int unsigned ITEM_TARGET   = 850;
  localparam int unsigned REPORT_LIMIT  = 10;

  class length_scoreboard;
    logic [hcle_pkg::TERM_W-1:0]       term_state;
    logic [hcle_pkg::LABEL_PROG_W-1:0] label_pos;
    bit                                label_seen;
    bit                                digits_done;
    logic [5:0]                        digit_total;
    logic [hcle_pkg::VALUE_W-1:0]      length_acc;
    hcle_pkg::result_t                 expected_q[$];
    int unsigned                       mismatches;
    int unsigned                       predicted;

    function new();
      mismatches = 0;
      predicted  = 0;
      clear_header();
    endfunction

    function void clear_header();
      term_state  = hcle_pkg::TERM_NONE;
      label_pos   = '0;
      label_seen  = 1'b0;
      digits_done = 1'b0;
      digit_total = '0;
      length_acc  = '0;
    endfunction

    function void note_item(logic [7:0] data, logic closed);
      logic [63:0]       next_val;
      hcle_pkg::result_t res;
      if (closed) begin
        res.content_length  = '0;
        res.label_found     = label_seen;
        res.header_complete = 1'b0;
        expected_q.push_back(res);
        predicted++;
        clear_header();
      end else begin
        if (label_seen) begin
          if (!digits_done) begin
            if (data >= hcle_pkg::CHAR_ZERO && data <= hcle_pkg::CHAR_NINE &&
                digit_total < hcle_pkg::MAX_DIGITS_DEF) begin
              next_val = 64'(length_acc) * 10 + 64'(data - hcle_pkg::CHAR_ZERO);
              length_acc = (next_val > 64'(hcle_pkg::VALUE_MAX)) ?
                           hcle_pkg::VALUE_MAX : next_val[hcle_pkg::VALUE_W-1:0];
              digit_total++;
              if (digit_total >= hcle_pkg::MAX_DIGITS_DEF) digits_done = 1'b1;
            end else begin
              digits_done = 1'b1;
            end
          end
        end else begin
          if (data == hcle_pkg::LABEL_TEXT[label_pos]) label_pos++;
          else label_pos = (data == hcle_pkg::LABEL_TEXT[0]) ?
                           hcle_pkg::LABEL_PROG_W'(1) : '0;
          if (label_pos == hcle_pkg::LABEL_DONE) label_seen = 1'b1;
        end
        if (data == hcle_pkg::CHAR_CR) begin
          term_state = (term_state == hcle_pkg::TERM_CRLF) ?
                       hcle_pkg::TERM_CRLFCR : hcle_pkg::TERM_CR;
        end else if (data == hcle_pkg::CHAR_LF && (term_state == hcle_pkg::TERM_CR ||
                                                   term_state == hcle_pkg::TERM_CRLFCR)) begin
          term_state = term_state + 1'b1;
        end else begin
          term_state = hcle_pkg::TERM_NONE;
        end
        if (term_state == hcle_pkg::TERM_DONE) begin
          res.content_length  = (label_seen && digit_total != 0) ? length_acc : '0;
          res.label_found     = label_seen;
          res.header_complete = 1'b1;
          expected_q.push_back(res);
          predicted++;
          clear_header();
        end
      end
    endfunction

    function void check_result(logic [31:0] data, logic done);
      hcle_pkg::result_t exp;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: len=%0d label=%0b complete=%0b",
                   data[30:0], data[31], done);
      end else begin
        exp = expected_q.pop_front();
        if (data[30:0] !== exp.content_length || data[31] !== exp.label_found ||
            done !== exp.header_complete) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display({"result mismatch: expected len=%0d label=%0b complete=%0b,",
                      " got len=%0d label=%0b complete=%0b"},
                     exp.content_length, exp.label_found, exp.header_complete,
                     data[30:0], data[31], done);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;

  length_scoreboard sb = new();
  logic [8:0]       item_q[$];
  int unsigned      items_sent    = 0;
  int unsigned      quiet_cycles  = 0;
  int unsigned      send_idle_pct = 23;
  int unsigned      recv_idle_pct = 77;
  bit               hold_req      = 1'b0;

  http_content_length_extractor dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_item(s_axis_tdata, s_axis_tuser);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("http_content_length_extractor regression: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // hold off for a long stretch once requested, else stall at random
  initial begin
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        @(posedge clk);
      end
    end
  end

  function automatic void add_byte(logic [7:0] b);
    item_q.push_back({1'b0, b});
  endfunction

  function automatic void add_label(int unsigned n);
    for (int unsigned i = 0; i < n; i++) add_byte(hcle_pkg::LABEL_TEXT[i]);
  endfunction

  function automatic void add_filler(int unsigned n);
    repeat (n) add_byte(8'($urandom_range(32, 126)));
  endfunction

  function automatic void add_digits(int unsigned n);
    repeat (n) add_byte(hcle_pkg::CHAR_ZERO + 8'($urandom_range(9)));
  endfunction

  function automatic void add_line_end();
    add_byte(hcle_pkg::CHAR_CR);
    add_byte(hcle_pkg::CHAR_LF);
  endfunction

  function automatic void build_header();
    int unsigned pick;
    int unsigned len_kind;
    int unsigned digits;
    pick = $urandom_range(99);
    if (pick < 10) begin
      repeat ($urandom_range(1, 20)) add_byte(8'($urandom_range(255)));
      if ($urandom_range(2) == 0) item_q.push_back({1'b1, 8'($urandom_range(255))});
    end else begin
      if ($urandom_range(3) == 0) begin
        add_filler($urandom_range(2, 8));
        add_line_end();
      end
      if ($urandom_range(4) == 0) add_label($urandom_range(1, hcle_pkg::LABEL_LEN - 1));
      if ($urandom_range(9) != 0) begin
        add_label(hcle_pkg::LABEL_LEN);
        len_kind = $urandom_range(99);
        if (len_kind < 10)      digits = 0;
        else if (len_kind < 80) digits = $urandom_range(1, 9);
        else if (len_kind < 94) digits = $urandom_range(10, 20);
        else                    digits = $urandom_range(hcle_pkg::MAX_DIGITS_DEF - 3,
                                                        hcle_pkg::MAX_DIGITS_DEF + 3);
        add_digits(digits);
        if ($urandom_range(3) == 0) add_filler($urandom_range(1, 4));
        add_line_end();
        if ($urandom_range(4) == 0) begin
          add_label(hcle_pkg::LABEL_LEN);
          add_digits($urandom_range(1, 3));
          add_line_end();
        end
      end else begin
        add_filler($urandom_range(2, 8));
        add_line_end();
      end
      add_line_end();
      if (pick < 18) begin
        repeat ($urandom_range(1, item_q.size() - 1)) void'(item_q.pop_back());
        item_q.push_back({1'b1, 8'($urandom_range(255))});
      end
    end
  endfunction

  task automatic send_item(logic [8:0] entry);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= entry[7:0];
    s_axis_tuser  <= entry[8];
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_queued();
    while (item_q.size() != 0) send_item(item_q.pop_front());
  endtask

  task automatic wait_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned phase;
    phase = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // close with no header pending, byte extremes, close carrying a byte
    item_q.push_back({1'b1, 8'h00});
    add_byte(8'h00);
    add_byte(8'hFF);
    item_q.push_back({1'b1, 8'hFF});
    // label restart on a doubled first letter, then terminator fallbacks
    add_byte(hcle_pkg::LABEL_TEXT[0]);
    add_label(hcle_pkg::LABEL_LEN);
    add_byte(hcle_pkg::CHAR_NINE);
    add_byte(hcle_pkg::CHAR_CR);
    add_byte(hcle_pkg::CHAR_CR);
    add_byte(hcle_pkg::CHAR_LF);
    add_byte(hcle_pkg::CHAR_CR);
    add_byte(hcle_pkg::CHAR_CR);
    add_byte(hcle_pkg::CHAR_LF);
    add_byte(hcle_pkg::CHAR_CR);
    add_byte(hcle_pkg::CHAR_LF);
    send_queued();

    while (items_sent < ITEM_TARGET) begin
      if (phase == 0 && items_sent >= ITEM_TARGET / 3) begin
        phase = 1;
        send_idle_pct = 77;
        recv_idle_pct = 23;
      end else if (phase == 1 && items_sent >= 2 * ITEM_TARGET / 3) begin
        phase = 2;
        wait_results();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b1;
      end
      build_header();
      send_queued();
    end

    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("http_content_length_extractor regression: pass");
    end else begin
      $display("http_content_length_extractor regression: fail");
    end
    $finish;
  end

endmodule
